### hw/rtl/oaht_pkg.sv
// Shared types and constants of the open-addressing hash table.
package oaht_pkg;

	localparam int SLOTS   = 1024;
	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;
	localparam int HASH_W  = 64;
	localparam int IDX_W   = $clog2(SLOTS);
	localparam int CNT_W   = IDX_W + 1;
	localparam int CFG_W   = 11;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_NOP    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		OC_NEW     = 3'd0,
		OC_PRESENT = 3'd1,
		OC_FOUND   = 3'd2,
		OC_REMOVED = 3'd3,
		OC_MISSING = 3'd4,
		OC_FULL    = 3'd5
	} outcome_t;

	typedef enum logic [1:0] {
		SS_EMPTY = 2'd0,
		SS_LIVE  = 2'd1,
		SS_TOMB  = 2'd2
	} slot_st_t;

	typedef enum logic [1:0] {
		PM_LINEAR    = 2'd0,
		PM_QUADRATIC = 2'd1,
		PM_DOUBLE    = 2'd2,
		PM_RESERVED  = 2'd3
	} pmode_t;

	typedef enum logic [0:0] {
		REG_PROBE_MODE = 1'b0,
		REG_TABLE_SIZE = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		FS_CLEAR,
		FS_IDLE,
		FS_DIV,
		FS_ADDR,
		FS_CHECK,
		FS_FIN
	} fsm_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [KEY_W-1:0]   key;
		logic [HASH_W-1:0]  hash;
		logic [VALUE_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic [2:0]         outcome;
		logic [VALUE_W-1:0] result_value;
		logic [IDX_W-1:0]   slot_index;
		logic [CNT_W-1:0]   live_count;
		logic [CNT_W-1:0]   used_count;
	} out_t;

	typedef struct packed {
		logic     ld_in;
		logic     init;
		logic     advance;
		logic     wr_live;
		logic     wr_tomb;
		logic     set_res;
		outcome_t oc;
		logic     ld_out;
	} dp_cmd_t;

	typedef struct packed {
		logic     clr_done;
		logic     div_busy;
		op_t      op;
		slot_st_t rd_st;
		logic     key_eq;
		logic     last;
		logic     out_free;
	} dp_stat_t;

endpackage

### hw/rtl/open_addressing_hash_table.sv
// Top level of the open-addressing hash table.
//   channel  dir  handshake             payload
//   in       in   in_valid/in_ready      in_data (cmd, key, hash, value)
//   out      out  out_valid/out_ready    out_data (outcome, value, slot, counts)
//   cfg      in   cfg_we                 cfg_index, cfg_wdata
// A command other than a NOP runs the bit-serial hash remainder, then one
// memory read and one check per probe, then the hand-off.
// After reset a clearing pass empties the status memory; in_ready stays
// low until it ends. A waiting result stalls only the finish of the next
// command, not its acceptance.
module open_addressing_hash_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  oaht_pkg::in_t              in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output oaht_pkg::out_t             out_data,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [oaht_pkg::CFG_W-1:0] cfg_wdata
);

	oaht_pkg::dp_cmd_t  c;
	oaht_pkg::dp_stat_t st;

	oaht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_cmd   (in_data.cmd),
		.st       (st),
		.c        (c)
	);

	oaht_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.c         (c),
		.st        (st)
	);

endmodule

### hw/rtl/oaht_mod.sv
// Bit-serial remainder unit: hash mod m and hash mod (m-1) side by side.
module oaht_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [oaht_pkg::HASH_W-1:0] hash,
	input  logic [oaht_pkg::CNT_W-1:0]  div_a,
	input  logic [oaht_pkg::CNT_W-1:0]  div_b,
	output logic                        busy,
	output logic [oaht_pkg::IDX_W-1:0]  rem_a,
	output logic [oaht_pkg::IDX_W-1:0]  rem_b
);

	localparam int BIT_W = $clog2(oaht_pkg::HASH_W);

	logic [oaht_pkg::HASH_W-1:0] sh_q;
	logic [BIT_W-1:0]            bit_q;
	logic                        busy_q;
	logic [oaht_pkg::IDX_W-1:0]  ra_q, rb_q;
	logic [oaht_pkg::CNT_W-1:0]  ta, tb;

	always_comb begin
		ta = {ra_q, sh_q[oaht_pkg::HASH_W-1]};
		tb = {rb_q, sh_q[oaht_pkg::HASH_W-1]};
		if (ta >= div_a) ta = ta - div_a;
		if (tb >= div_b) tb = tb - div_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bit_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			bit_q  <= '1;
		end else if (busy_q) begin
			bit_q <= bit_q - 1'b1;
			if (bit_q == '0) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= hash;
			ra_q <= '0;
			rb_q <= '0;
		end else if (busy_q) begin
			// shift in one dividend bit, keep both partial remainders
			sh_q <= {sh_q[oaht_pkg::HASH_W-2:0], 1'b0};
			ra_q <= ta[oaht_pkg::IDX_W-1:0];
			rb_q <= tb[oaht_pkg::IDX_W-1:0];
		end
	end

	assign busy  = busy_q;
	assign rem_a = ra_q;
	assign rem_b = rb_q;

endmodule

### hw/rtl/oaht_dp.sv
// Datapath: slot memories, probe sequence, counters and the result register.
module oaht_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  oaht_pkg::in_t                 in_data,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [oaht_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                          out_ready,
	output logic                          out_valid,
	output oaht_pkg::out_t                out_data,
	input  oaht_pkg::dp_cmd_t             c,
	output oaht_pkg::dp_stat_t            st
);

	localparam int IW = oaht_pkg::IDX_W;
	localparam int CW = oaht_pkg::CNT_W;

	logic [1:0]    mode_cfg_q;
	logic [CW-1:0] size_cfg_q;

	logic [1:0]                   op_q;
	logic [1:0]                   mode_q;
	logic [oaht_pkg::KEY_W-1:0]   key_q;
	logic [oaht_pkg::VALUE_W-1:0] val_q;
	logic [CW-1:0]                m_q, m_act, m1;
	logic [IW-1:0]                z_q, inc_q, inc_init, two_mod;
	logic [CW-1:0]                cnt_q, zsum, isum;
	logic [IW-1:0]                r_a, r_b;
	logic                         div_busy;

	logic [1:0]                   status_mem [oaht_pkg::SLOTS];
	logic [oaht_pkg::KEY_W-1:0]   key_mem    [oaht_pkg::SLOTS];
	logic [oaht_pkg::VALUE_W-1:0] val_mem    [oaht_pkg::SLOTS];
	logic [1:0]                   rd_st_q;
	logic [oaht_pkg::KEY_W-1:0]   rd_key_q;
	logic [oaht_pkg::VALUE_W-1:0] rd_val_q;

	logic [CW-1:0] clr_q;
	logic [CW-1:0] live_q, used_q;

	logic [2:0]                   oc_q;
	logic [oaht_pkg::VALUE_W-1:0] rv_q;
	logic [IW-1:0]                slot_q;
	logic                         ov_q;
	oaht_pkg::out_t               out_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_cfg_q <= oaht_pkg::PM_LINEAR;
			size_cfg_q <= CW'(oaht_pkg::SLOTS);
		end else if (cfg_we) begin
			case (cfg_index)
				oaht_pkg::REG_PROBE_MODE: mode_cfg_q <= cfg_wdata[1:0];
				oaht_pkg::REG_TABLE_SIZE: size_cfg_q <= cfg_wdata[CW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		m_act = size_cfg_q;
		if (size_cfg_q == '0) m_act = CW'(1);
		if (size_cfg_q > CW'(oaht_pkg::SLOTS)) m_act = CW'(oaht_pkg::SLOTS);
	end

	assign m1 = (m_q > CW'(1)) ? m_q - CW'(1) : CW'(1);

	oaht_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (c.ld_in),
		.hash   (in_data.hash),
		.div_a  (m_q),
		.div_b  (m1),
		.busy   (div_busy),
		.rem_a  (r_a),
		.rem_b  (r_b)
	);

	// probe sequence
	always_comb begin
		two_mod = (m_q > CW'(2)) ? IW'(2) : '0;
		if (m_q == CW'(1))
			inc_init = '0;
		else if (mode_q == oaht_pkg::PM_DOUBLE)
			inc_init = r_b + IW'(1);
		else
			inc_init = IW'(1);
		zsum = {1'b0, z_q} + {1'b0, inc_q};
		if (zsum >= m_q) zsum = zsum - m_q;
		isum = {1'b0, inc_q} + {1'b0, two_mod};
		if (isum >= m_q) isum = isum - m_q;
	end

	always_ff @(posedge clk) begin
		if (c.ld_in) begin
			op_q   <= in_data.cmd;
			key_q  <= in_data.key;
			val_q  <= in_data.value;
			m_q    <= m_act;
			mode_q <= (mode_cfg_q == oaht_pkg::PM_RESERVED) ?
				oaht_pkg::PM_LINEAR : mode_cfg_q;
		end
		if (c.init) begin
			z_q   <= r_a;
			inc_q <= inc_init;
			cnt_q <= CW'(1);
		end else if (c.advance) begin
			z_q   <= zsum[IW-1:0];
			cnt_q <= cnt_q + CW'(1);
			if (mode_q == oaht_pkg::PM_QUADRATIC) inc_q <= isum[IW-1:0];
		end
	end

	// clearing pass over the status memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (!clr_q[CW-1]) clr_q <= clr_q + CW'(1);
	end

	always_ff @(posedge clk) begin
		if (!clr_q[CW-1])
			status_mem[clr_q[IW-1:0]] <= oaht_pkg::SS_EMPTY;
		else if (c.wr_live)
			status_mem[z_q] <= oaht_pkg::SS_LIVE;
		else if (c.wr_tomb)
			status_mem[z_q] <= oaht_pkg::SS_TOMB;
		if (c.wr_live) begin
			key_mem[z_q] <= key_q;
			val_mem[z_q] <= val_q;
		end
		rd_st_q  <= status_mem[z_q];
		rd_key_q <= key_mem[z_q];
		rd_val_q <= val_mem[z_q];
	end

	// slot counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			used_q <= '0;
		end else if (c.wr_live) begin
			live_q <= live_q + CW'(1);
			if (rd_st_q == oaht_pkg::SS_EMPTY) used_q <= used_q + CW'(1);
		end else if (c.wr_tomb) begin
			live_q <= live_q - CW'(1);
		end
	end

	// result of the current command
	always_ff @(posedge clk) begin
		if (c.ld_in) begin
			oc_q   <= oaht_pkg::OC_MISSING;
			rv_q   <= '0;
			slot_q <= '0;
		end else if (c.set_res) begin
			oc_q   <= c.oc;
			slot_q <= (c.oc == oaht_pkg::OC_FULL) ? '0 : z_q;
			rv_q   <= (c.oc inside {oaht_pkg::OC_FOUND, oaht_pkg::OC_REMOVED}) ?
				rd_val_q : '0;
		end
		if (c.ld_out) begin
			out_q.outcome      <= oc_q;
			out_q.result_value <= rv_q;
			out_q.slot_index   <= slot_q;
			out_q.live_count   <= live_q;
			out_q.used_count   <= used_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (c.ld_out) ov_q <= 1'b1;
		else if (out_ready) ov_q <= 1'b0;
	end

	assign out_valid = ov_q;
	assign out_data  = out_q;

	assign st.clr_done = clr_q[CW-1];
	assign st.div_busy = div_busy;
	assign st.op       = oaht_pkg::op_t'(op_q);
	assign st.rd_st    = oaht_pkg::slot_st_t'(rd_st_q);
	assign st.key_eq   = (rd_key_q == key_q);
	assign st.last     = (cnt_q == m_q);
	assign st.out_free = !ov_q || out_ready;

`ifndef NO_ASSERTIONS
	a_live_le_used: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= used_q) else $error("live count above used count");
	a_used_max: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(oaht_pkg::SLOTS)) else $error("used count overflow");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(c.wr_live && c.wr_tomb)) else $error("two slot writes at once");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		c.ld_out |-> (!ov_q || out_ready)) else $error("result overwritten");
`endif

endmodule

### hw/rtl/oaht_ctrl.sv
// Controller: sequences clearing, hashing, probing and result hand-off.
module oaht_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         in_cmd,
	input  oaht_pkg::dp_stat_t st,
	output oaht_pkg::dp_cmd_t  c
);

	oaht_pkg::fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= oaht_pkg::FS_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		c        = '0;
		c.oc     = oaht_pkg::OC_MISSING;
		case (state_q)
			oaht_pkg::FS_CLEAR: begin
				if (st.clr_done) state_d = oaht_pkg::FS_IDLE;
			end
			oaht_pkg::FS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					c.ld_in = 1'b1;
					state_d = (in_cmd == oaht_pkg::CMD_NOP) ?
						oaht_pkg::FS_FIN : oaht_pkg::FS_DIV;
				end
			end
			oaht_pkg::FS_DIV: begin
				if (!st.div_busy) begin
					c.init  = 1'b1;
					state_d = oaht_pkg::FS_ADDR;
				end
			end
			oaht_pkg::FS_ADDR: state_d = oaht_pkg::FS_CHECK;
			oaht_pkg::FS_CHECK: begin
				state_d = oaht_pkg::FS_FIN;
				if (st.op == oaht_pkg::CMD_INSERT) begin
					if (st.rd_st != oaht_pkg::SS_LIVE) begin
						c.wr_live = 1'b1;
						c.set_res = 1'b1;
						c.oc      = oaht_pkg::OC_NEW;
					end else if (st.key_eq) begin
						c.set_res = 1'b1;
						c.oc      = oaht_pkg::OC_PRESENT;
					end else if (st.last) begin
						c.set_res = 1'b1;
						c.oc      = oaht_pkg::OC_FULL;
					end else begin
						c.advance = 1'b1;
						state_d   = oaht_pkg::FS_ADDR;
					end
				end else begin
					if (st.rd_st == oaht_pkg::SS_EMPTY) begin
						state_d = oaht_pkg::FS_FIN;
					end else if (st.rd_st == oaht_pkg::SS_LIVE && st.key_eq) begin
						c.set_res = 1'b1;
						if (st.op == oaht_pkg::CMD_REMOVE) begin
							c.wr_tomb = 1'b1;
							c.oc      = oaht_pkg::OC_REMOVED;
						end else begin
							c.oc = oaht_pkg::OC_FOUND;
						end
					end else if (!st.last) begin
						// skip tombstones and other keys
						c.advance = 1'b1;
						state_d   = oaht_pkg::FS_ADDR;
					end
				end
			end
			oaht_pkg::FS_FIN: begin
				if (st.out_free) begin
					c.ld_out = 1'b1;
					state_d  = oaht_pkg::FS_IDLE;
				end
			end
			default: state_d = oaht_pkg::FS_IDLE;
		endcase
	end

endmodule

### sim/testbench.sv
// Self-checking testbench of the open-addressing hash table.
`timescale 1ns / 100ps

module testbench;

	localparam string PASS_MSG = "** open_addressing_hash_table: PASSED **";

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	oaht_pkg::in_t              in_data;
	logic                       out_valid;
	logic                       out_ready;
	oaht_pkg::out_t             out_data;
	logic                       cfg_we;
	logic [0:0]                 cfg_index;
	logic [oaht_pkg::CFG_W-1:0] cfg_wdata;

	open_addressing_hash_table dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// Shadow copy of the table.
	oaht_pkg::slot_st_t           shadow_st [oaht_pkg::SLOTS];
	logic [oaht_pkg::KEY_W-1:0]   shadow_key [oaht_pkg::SLOTS];
	logic [oaht_pkg::VALUE_W-1:0] shadow_val [oaht_pkg::SLOTS];
	int unsigned                  shadow_live;
	int unsigned                  shadow_used;
	logic [1:0]                   mode_reg;
	logic [oaht_pkg::CFG_W-1:0]   size_reg;

	oaht_pkg::out_t pending_results [$];
	int   errors;
	int   results_seen;
	int   beats_sent;
	bit   hold_out;
	bit   no_idle;

	// Recent keys and hashes, reused so that searches and removes hit.
	logic [oaht_pkg::KEY_W-1:0]  key_pool [$];
	logic [oaht_pkg::HASH_W-1:0] hash_pool [$];

	typedef struct {
		oaht_pkg::in_t  beat;
		bit             known;
		oaht_pkg::out_t want;
	} row_t;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("** open_addressing_hash_table: FAILED **");
		$finish;
	end

	function automatic int unsigned probe_at(logic [oaht_pkg::HASH_W-1:0] h,
			int unsigned i, int unsigned m);
		longint unsigned base, step, d;
		base = h % m;
		if (mode_reg == oaht_pkg::PM_QUADRATIC)
			step = (longint'(i) * i) % m;
		else if (mode_reg == oaht_pkg::PM_DOUBLE) begin
			d = 1 + h % ((m > 1) ? m - 1 : 1);
			step = (longint'(i) * d) % m;
		end else
			step = i % m;
		return 32'((base + step) % m);
	endfunction

	function automatic oaht_pkg::out_t table_lookup(oaht_pkg::in_t c);
		oaht_pkg::out_t r;
		int unsigned m, z;
		m = 32'(size_reg);
		if (m == 0) m = 1;
		if (m > oaht_pkg::SLOTS) m = oaht_pkg::SLOTS;
		r = '0;
		r.outcome = oaht_pkg::OC_MISSING;
		if (c.cmd == oaht_pkg::CMD_INSERT) begin
			r.outcome = oaht_pkg::OC_FULL;
			for (int unsigned i = 0; i < m; i++) begin
				z = probe_at(c.hash, i, m);
				if (shadow_st[z] != oaht_pkg::SS_LIVE) begin
					if (shadow_st[z] == oaht_pkg::SS_EMPTY) shadow_used++;
					shadow_st[z] = oaht_pkg::SS_LIVE;
					shadow_key[z] = c.key;
					shadow_val[z] = c.value;
					shadow_live++;
					r.outcome = oaht_pkg::OC_NEW;
					r.slot_index = (oaht_pkg::IDX_W)'(z);
					break;
				end
				if (shadow_key[z] == c.key) begin
					r.outcome = oaht_pkg::OC_PRESENT;
					r.slot_index = (oaht_pkg::IDX_W)'(z);
					break;
				end
			end
		end else if (c.cmd == oaht_pkg::CMD_SEARCH || c.cmd == oaht_pkg::CMD_REMOVE) begin
			for (int unsigned i = 0; i < m; i++) begin
				z = probe_at(c.hash, i, m);
				if (shadow_st[z] == oaht_pkg::SS_TOMB) continue;
				if (shadow_st[z] == oaht_pkg::SS_EMPTY) break;
				if (shadow_key[z] == c.key) begin
					r.result_value = shadow_val[z];
					r.slot_index = (oaht_pkg::IDX_W)'(z);
					if (c.cmd == oaht_pkg::CMD_REMOVE) begin
						shadow_st[z] = oaht_pkg::SS_TOMB;
						shadow_live--;
						r.outcome = oaht_pkg::OC_REMOVED;
					end else
						r.outcome = oaht_pkg::OC_FOUND;
					break;
				end
			end
		end
		r.live_count = shadow_live[oaht_pkg::CNT_W-1:0];
		r.used_count = shadow_used[oaht_pkg::CNT_W-1:0];
		return r;
	endfunction

	// Result side: random stalls, long hold-off on request.
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$error("result beat with nothing expected: %p", out_data);
					errors++;
				end else begin
					oaht_pkg::out_t w;
					w = pending_results.pop_front();
					if (out_data.outcome !== w.outcome) begin
						$error("outcome: expected %0d, got %0d", w.outcome, out_data.outcome);
						errors++;
					end
					if (out_data.result_value !== w.result_value) begin
						$error("result_value: expected %h, got %h", w.result_value,
							out_data.result_value);
						errors++;
					end
					if (out_data.slot_index !== w.slot_index) begin
						$error("slot_index: expected %0d, got %0d", w.slot_index,
							out_data.slot_index);
						errors++;
					end
					if (out_data.live_count !== w.live_count) begin
						$error("live_count: expected %0d, got %0d", w.live_count,
							out_data.live_count);
						errors++;
					end
					if (out_data.used_count !== w.used_count) begin
						$error("used_count: expected %0d, got %0d", w.used_count,
							out_data.used_count);
						errors++;
					end
				end
			end
			out_ready <= !hold_out && (no_idle || $urandom_range(99) >= 32);
		end
	end

	// One write beat, then the task waits with the write enable low.
	task automatic write_reg(oaht_pkg::reg_idx_t idx, logic [oaht_pkg::CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == oaht_pkg::REG_PROBE_MODE) mode_reg = data[1:0];
		else size_reg = data;
		@(posedge clk);
	endtask

	// Drop valid, wait until every result is in, then idle before returning.
	task automatic drain;
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (pending_results.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		if (pending_results.size() != 0) begin
			$display("** open_addressing_hash_table: FAILED **");
			$finish;
		end
		repeat (80) @(posedge clk);
	endtask

	// Offer one beat; the expectation is queued at acceptance. Valid stays
	// high after the beat so the next one can follow; drain drops it.
	task automatic send(oaht_pkg::in_t c, bit known, oaht_pkg::out_t want);
		oaht_pkg::out_t r;
		if (!no_idle)
			while ($urandom_range(99) < 32) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		in_data <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = table_lookup(c);
		if (known && r !== want) begin
			$error("directed row: expected %p, model gives %p", want, r);
			errors++;
		end
		pending_results.push_back(r);
		beats_sent++;
	endtask

	function automatic oaht_pkg::in_t make_cmd(bit keyed, int unsigned span);
		oaht_pkg::in_t c;
		int k;
		c.cmd = $urandom_range(99) < 3 ? oaht_pkg::CMD_NOP :
			oaht_pkg::op_t'($urandom_range(2));
		c.value = $urandom;
		if (keyed && key_pool.size() != 0 && $urandom_range(99) < 60) begin
			k = $urandom_range(key_pool.size() - 1);
			c.key = key_pool[k];
			c.hash = hash_pool[k];
		end else begin
			c.key = $urandom_range(span);
			c.hash = {$urandom, $urandom};
			if ($urandom_range(3) == 0) c.key = $urandom;
			key_pool.push_back(c.key);
			hash_pool.push_back(c.hash);
			if (key_pool.size() > 40) begin
				void'(key_pool.pop_front());
				void'(hash_pool.pop_front());
			end
		end
		return c;
	endfunction

	task automatic random_phase(int count, logic [1:0] pmode,
			logic [oaht_pkg::CFG_W-1:0] sz);
		drain();
		write_reg(oaht_pkg::REG_PROBE_MODE, pmode);
		write_reg(oaht_pkg::REG_TABLE_SIZE, sz);
		for (int i = 0; i < count; i++)
			send(make_cmd(1'b1, 1000), 1'b0, '0);
	endtask

	function automatic row_t row(oaht_pkg::op_t op, logic [oaht_pkg::KEY_W-1:0] k,
			logic [oaht_pkg::HASH_W-1:0] h, logic [oaht_pkg::VALUE_W-1:0] v, bit known,
			oaht_pkg::outcome_t oc, logic [oaht_pkg::VALUE_W-1:0] rv,
			logic [oaht_pkg::IDX_W-1:0] sl, logic [oaht_pkg::CNT_W-1:0] lv,
			logic [oaht_pkg::CNT_W-1:0] us);
		row_t r;
		r.beat = '{cmd: op, key: k, hash: h, value: v};
		r.known = known;
		r.want = '{outcome: oc, result_value: rv, slot_index: sl, live_count: lv,
			used_count: us};
		return r;
	endfunction

	initial begin
		row_t rows [$];
		logic [oaht_pkg::HASH_W-1:0] hmax;
		errors = 0;
		results_seen = 0;
		beats_sent = 0;
		hold_out = 1'b0;
		no_idle = 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= oaht_pkg::REG_PROBE_MODE;
		cfg_wdata <= '0;
		for (int i = 0; i < oaht_pkg::SLOTS; i++) begin
			shadow_st[i] = oaht_pkg::SS_EMPTY;
			shadow_key[i] = '0;
			shadow_val[i] = '0;
		end
		shadow_live = 0;
		shadow_used = 0;
		mode_reg = oaht_pkg::PM_LINEAR;
		size_reg = 11'd1024;
		hmax = '1;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rows at reset settings: 1024 slots, linear probing.
		rows.push_back(row(oaht_pkg::CMD_SEARCH, 32'd5, 64'd5, 32'd0, 1,
			oaht_pkg::OC_MISSING, 0, 0, 0, 0));
		rows.push_back(row(oaht_pkg::CMD_INSERT, 32'd5, 64'd5, 32'hFFFF_FFFF, 1,
			oaht_pkg::OC_NEW, 0, 5, 1, 1));
		rows.push_back(row(oaht_pkg::CMD_INSERT, 32'd5, 64'd5, 32'd1, 1,
			oaht_pkg::OC_PRESENT, 0, 5, 1, 1));
		rows.push_back(row(oaht_pkg::CMD_SEARCH, 32'd5, 64'd5, 32'd0, 1,
			oaht_pkg::OC_FOUND, 32'hFFFF_FFFF, 5, 1, 1));
		rows.push_back(row(oaht_pkg::CMD_INSERT, 32'hFFFF_FFFF, hmax, 32'd0, 1,
			oaht_pkg::OC_NEW, 0, 1023, 2, 2));
		rows.push_back(row(oaht_pkg::CMD_INSERT, 32'd0, 64'd1023, 32'd7, 1,
			oaht_pkg::OC_NEW, 0, 0, 3, 3));
		rows.push_back(row(oaht_pkg::CMD_REMOVE, 32'hFFFF_FFFF, hmax, 32'd0, 1,
			oaht_pkg::OC_REMOVED, 0, 1023, 2, 3));
		rows.push_back(row(oaht_pkg::CMD_SEARCH, 32'd0, 64'd1023, 32'd0, 1,
			oaht_pkg::OC_FOUND, 7, 0, 2, 3));
		rows.push_back(row(oaht_pkg::CMD_REMOVE, 32'hFFFF_FFFF, hmax, 32'd0, 1,
			oaht_pkg::OC_MISSING, 0, 0, 2, 3));
		rows.push_back(row(oaht_pkg::CMD_INSERT, 32'd9, hmax, 32'd9, 1,
			oaht_pkg::OC_NEW, 0, 1023, 3, 3));
		rows.push_back(row(oaht_pkg::CMD_NOP, 32'd5, 64'd5, 32'd0, 1,
			oaht_pkg::OC_MISSING, 0, 0, 3, 3));
		rows.push_back(row(oaht_pkg::CMD_INSERT, 32'd6, 64'd5, 32'h1234, 0,
			oaht_pkg::OC_NEW, 0, 0, 0, 0));
		rows.push_back(row(oaht_pkg::CMD_SEARCH, 32'd6, 64'd5, 32'd0, 0,
			oaht_pkg::OC_NEW, 0, 0, 0, 0));
		rows.push_back(row(oaht_pkg::CMD_REMOVE, 32'd5, 64'd5, 32'd0, 0,
			oaht_pkg::OC_NEW, 0, 0, 0, 0));
		rows.push_back(row(oaht_pkg::CMD_SEARCH, 32'd6, 64'd5, 32'd0, 0,
			oaht_pkg::OC_NEW, 0, 0, 0, 0));
		foreach (rows[i]) send(rows[i].beat, rows[i].known, rows[i].want);

		// Tiny tables: size zero acts as one, then fill until full; last, reserved mode and oversize.
		drain();
		write_reg(oaht_pkg::REG_TABLE_SIZE, 11'd0);
		send('{cmd: oaht_pkg::CMD_INSERT, key: 32'd77, hash: hmax, value: 32'd1}, 0, '0);
		send('{cmd: oaht_pkg::CMD_INSERT, key: 32'd78, hash: 64'd0, value: 32'd2}, 0, '0);
		drain();
		write_reg(oaht_pkg::REG_PROBE_MODE, oaht_pkg::PM_DOUBLE);
		write_reg(oaht_pkg::REG_TABLE_SIZE, 11'd3);
		for (int i = 0; i < 5; i++)
			send('{cmd: oaht_pkg::CMD_INSERT, key: 32'd100 + i, hash: {$urandom, $urandom},
				value: $urandom}, 0, '0);
		send('{cmd: oaht_pkg::CMD_REMOVE, key: 32'd101, hash: 64'd0, value: 32'd0}, 0, '0);
		drain();
		write_reg(oaht_pkg::REG_PROBE_MODE, oaht_pkg::PM_RESERVED);
		write_reg(oaht_pkg::REG_TABLE_SIZE, 11'h7FF);
		send('{cmd: oaht_pkg::CMD_SEARCH, key: 32'd5, hash: 64'd5, value: 32'd0}, 0, '0);

		// Receiver holds off while the sender keeps offering.
		drain();
		hold_out = 1'b1;
		fork
			for (int i = 0; i < 6; i++) send(make_cmd(1'b1, 1000), 1'b0, '0);
			begin
				repeat (2000) @(posedge clk);
				hold_out = 1'b0;
			end
		join

		random_phase(120, oaht_pkg::PM_LINEAR, 11'd64);
		random_phase(100, oaht_pkg::PM_QUADRATIC, 11'd31);
		no_idle = 1'b1;
		random_phase(80, oaht_pkg::PM_DOUBLE, 11'd97);
		no_idle = 1'b0;
		random_phase(60, oaht_pkg::PM_LINEAR, 11'd1);
		random_phase(50, oaht_pkg::PM_DOUBLE, 11'd2);
		random_phase(60, oaht_pkg::PM_QUADRATIC, 11'd1024);
		random_phase(40, oaht_pkg::PM_DOUBLE, 11'd1024);

		drain();
		$display("Sent %0d commands, checked %0d results over probe modes 0..3 and",
			beats_sent, results_seen);
		$display("table sizes 0 to 2047, including full tables and tombstone reuse.");
		if (errors == 0)
			$display(PASS_MSG);
		else
			$display("** open_addressing_hash_table: FAILED **");
		$finish;
	end

endmodule

### files.f
hw/rtl/oaht_pkg.sv
hw/rtl/oaht_mod.sv
hw/rtl/oaht_dp.sv
hw/rtl/oaht_ctrl.sv
hw/rtl/open_addressing_hash_table.sv
sim/testbench.sv
